// ----- rtl/circle_fill_span_generator_macros.svh -----
// assertion helpers used by the top level rtl module
`ifndef CIRCLE_FILL_SPAN_GENERATOR_MACROS_SVH
`define CIRCLE_FILL_SPAN_GENERATOR_MACROS_SVH

// same-cycle implication
`define CFS_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CFS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cfs_pkg.sv -----
package cfs_pkg;

   // field widths
   localparam int CENTER_W   = 12;
   localparam int RADIUS_W   = 7;
   localparam int COLOR_W    = 32;
   localparam int ROW_W      = 14;
   localparam int X_W        = 13;
   localparam int ADDR_W     = 32;
   localparam int PITCH_W    = 16;

   // stream widths, padded to whole bytes
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 152;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH = 1'b1;

   localparam logic [ADDR_W-1:0]  FRAME_BASE_RST = '0;
   localparam logic [PITCH_W-1:0] LINE_PITCH_RST = 16'd4096;

   // parameter defaults
   localparam int MAX_RADIUS_DEF      = 64;
   localparam int BYTES_PER_PIXEL_DEF = 4;

   typedef struct packed {
      logic [ADDR_W-1:0]  frame_base;
      logic [PITCH_W-1:0] line_pitch;
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_SEARCH,
      ST_ADDR_LO,
      ST_ADDR_HI,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/cfs_csr.sv -----
module cfs_csr
   import cfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output csr_type               csr
);

   csr_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.frame_base <= FRAME_BASE_RST;
         csr_ff.line_pitch <= LINE_PITCH_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_BASE: csr_ff.frame_base <= csr_wdata[ADDR_W-1:0];
            CSR_LINE_PITCH: csr_ff.line_pitch <= csr_wdata[PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr = csr_ff;

endmodule

// ----- rtl/cfs_sqrt_step.sv -----
module cfs_sqrt_step
   import cfs_pkg::*;
#(
   parameter int RW = 7,
   parameter int VW = 13
)
(
   input  logic [RW-1:0] w,
   input  logic [VW-1:0] sq,
   input  logic [VW-1:0] v,
   output logic          fit,
   output logic [RW-1:0] w_next,
   output logic [VW-1:0] sq_next
);

   // sq holds (w+1)^2; one more step is taken while it still fits under v
   assign fit     = (sq <= v);
   assign w_next  = w + RW'(1);
   assign sq_next = sq + (VW'(w) << 1) + VW'(3);

endmodule

// ----- rtl/cfs_addr_unit.sv -----
module cfs_addr_unit
   import cfs_pkg::*;
#(
   parameter int BYTES_PER_PIXEL = BYTES_PER_PIXEL_DEF
)
(
   input  csr_type                 csr,
   input  logic signed [ROW_W-1:0] row,
   input  logic signed [X_W-1:0]   x,
   output logic [ADDR_W-1:0]       addr
);

   logic [ADDR_W-1:0] row_ext;
   logic [ADDR_W-1:0] x_ext;
   logic [ADDR_W-1:0] row_term;
   logic [ADDR_W-1:0] x_term;

   // two's complement wrap at 32 bits
   assign row_ext  = {{(ADDR_W-ROW_W){row[ROW_W-1]}}, row};
   assign x_ext    = {{(ADDR_W-X_W){x[X_W-1]}}, x};
   assign row_term = row_ext * {{(ADDR_W-PITCH_W){1'b0}}, csr.line_pitch};
   assign x_term   = x_ext * ADDR_W'(BYTES_PER_PIXEL);
   assign addr     = csr.frame_base + row_term + x_term;

endmodule

// ----- rtl/circle_fill_span_generator.sv -----
// channel  | dir | ports                              | contents
// req      | in  | req_tvalid req_tready req_tdata    | one circle request
// rsp      | out | rsp_tvalid rsp_tready rsp_tdata    | one span pair, tlast on final pair
//          |     | rsp_tlast                          |
// csr      | in  | csr_wr_en csr_index csr_wdata      | frame_base, line_pitch writes
//
// a request is loaded, then each row runs advance, a search that steps the half
// width up while it fits, the lower and upper address passes and emit; the half
// width increments total r over the circle
// the incremental square root search runs in one shared step unit, and each row
// makes two passes through the shared address multiplier
// a zero radius request is absorbed in its transfer cycle, ready again next cycle
// reset is synchronous, active high; it clears the sequencer, d, w, r and last_ff
// rsp stalls hold the span pair and the whole sequencer; req_tready is low meanwhile
`include "circle_fill_span_generator_macros.svh"

module circle_fill_span_generator
   import cfs_pkg::*;
#(
   parameter int MAX_RADIUS      = MAX_RADIUS_DEF,
   parameter int BYTES_PER_PIXEL = BYTES_PER_PIXEL_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // center_x[11:0], center_y[23:12], radius[30:24], color[62:31], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // row_lower[13:0], row_upper[27:14], x_left[40:28], x_right[53:41],
   // addr_lower[85:54], addr_upper[117:86], span_color[149:118], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,

   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // width of row offset, radius and half width
   localparam int RW = $clog2(MAX_RADIUS + 1);
   // width of the radicand and of the running square (w+1)^2, up to (r+1)^2
   localparam int VW = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1);

   // request fields
   logic [CENTER_W-1:0] req_center_x;
   logic [CENTER_W-1:0] req_center_y;
   logic [RADIUS_W-1:0] req_radius;
   logic [COLOR_W-1:0]  req_color;
   logic [RW-1:0]       req_radius_sat;

   assign req_center_x = req_tdata[11:0];
   assign req_center_y = req_tdata[23:12];
   assign req_radius   = req_tdata[30:24];
   assign req_color    = req_tdata[62:31];

   // radius saturates to the largest supported value
   assign req_radius_sat = (req_radius > RADIUS_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                                : RW'(req_radius);

   // sequencer and iteration state
   state_type state_ff, state_in;

   logic [RW-1:0]       d_ff, d_in;       // row offset of the pair in work
   logic [RW-1:0]       w_ff, w_in;       // half width found so far
   logic [VW-1:0]       sq_ff, sq_in;     // (w+1)^2
   logic [VW-1:0]       v_ff, v_in;       // 2*r*d - d*d
   logic [RW-1:0]       r_ff, r_in;
   logic [CENTER_W-1:0] cx_ff, cx_in;
   logic [CENTER_W-1:0] cy_ff, cy_in;
   logic [COLOR_W-1:0]  color_ff, color_in;

   // output register
   logic signed [ROW_W-1:0] row_lower_ff, row_lower_in;
   logic signed [ROW_W-1:0] row_upper_ff, row_upper_in;
   logic signed [X_W-1:0]   x_left_ff, x_left_in;
   logic [X_W-1:0]          x_right_ff, x_right_in;
   logic [ADDR_W-1:0]       addr_lower_ff, addr_lower_in;
   logic [ADDR_W-1:0]       addr_upper_ff, addr_upper_in;
   logic [COLOR_W-1:0]      span_color_ff, span_color_in;
   logic                    last_ff, last_in;

   // control decoded from the state
   logic req_xfer;
   logic rsp_xfer;
   logic do_load;
   logic do_advance;
   logic do_grow;
   logic do_store_lo;
   logic do_store_hi;

   // shared units
   csr_type                 csr;
   logic                    step_fit;
   logic [RW-1:0]           step_w_next;
   logic [VW-1:0]           step_sq_next;
   logic signed [ROW_W-1:0] row_lower;
   logic signed [ROW_W-1:0] row_upper;
   logic signed [X_W-1:0]   x_left;
   logic [X_W-1:0]          x_right;
   logic signed [ROW_W-1:0] mul_row;
   logic [ADDR_W-1:0]       mul_addr;
   logic [VW-1:0]           v_delta;
   logic                    final_row;

   cfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   cfs_sqrt_step #(
      .RW (RW),
      .VW (VW)
   ) u_sqrt_step (
      .w       (w_ff),
      .sq      (sq_ff),
      .v       (v_ff),
      .fit     (step_fit),
      .w_next  (step_w_next),
      .sq_next (step_sq_next)
   );

   // lower row goes through the multiplier first, upper row next cycle
   assign mul_row = (state_ff == ST_ADDR_LO) ? row_lower : row_upper;

   cfs_addr_unit #(
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_addr_unit (
      .csr  (csr),
      .row  (mul_row),
      .x    (x_left),
      .addr (mul_addr)
   );

   // span geometry of the current pair
   assign row_lower = ROW_W'(cy_ff) + ROW_W'(r_ff) - ROW_W'(d_ff);
   assign row_upper = ROW_W'(cy_ff) - ROW_W'(r_ff) + ROW_W'(d_ff);
   assign x_left    = X_W'(cx_ff) - X_W'(w_ff);
   assign x_right   = X_W'(cx_ff) + X_W'(w_ff);
   assign final_row = (d_ff == r_ff);

   // v(d) - v(d-1) = 2*(r - (d-1)) - 1, taken before d steps up
   assign v_delta = (VW'(r_ff - d_ff) << 1) - VW'(1);

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_radius_sat != '0)) begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            // the half width never shrinks while d climbs to r
            if (!step_fit) begin
               state_in = ST_ADDR_LO;
            end
         end
         ST_ADDR_LO: begin
            state_in = ST_ADDR_HI;
         end
         ST_ADDR_HI: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               state_in = last_ff ? ST_IDLE : ST_ADVANCE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      do_advance  = 1'b0;
      do_grow     = 1'b0;
      do_store_lo = 1'b0;
      do_store_hi = 1'b0;
      case (state_ff)
         ST_IDLE:    req_tready  = 1'b1;
         ST_ADVANCE: do_advance  = 1'b1;
         ST_SEARCH:  do_grow     = step_fit;
         ST_ADDR_LO: do_store_lo = 1'b1;
         ST_ADDR_HI: do_store_hi = 1'b1;
         ST_EMIT:    rsp_tvalid  = 1'b1;
         default: ;
      endcase
   end

   assign do_load = req_xfer;

   // iteration datapath
   always_comb begin
      d_in     = d_ff;
      w_in     = w_ff;
      sq_in    = sq_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      color_in = color_ff;
      if (do_load) begin
         d_in     = '0;
         w_in     = '0;
         sq_in    = VW'(1);
         v_in     = '0;
         r_in     = req_radius_sat;
         cx_in    = req_center_x;
         cy_in    = req_center_y;
         color_in = req_color;
      end
      if (do_advance) begin
         d_in = d_ff + RW'(1);
         v_in = v_ff + v_delta;
      end
      if (do_grow) begin
         w_in  = step_w_next;
         sq_in = step_sq_next;
      end
   end

   // output register loads
   always_comb begin
      row_lower_in  = row_lower_ff;
      row_upper_in  = row_upper_ff;
      x_left_in     = x_left_ff;
      x_right_in    = x_right_ff;
      addr_lower_in = addr_lower_ff;
      addr_upper_in = addr_upper_ff;
      span_color_in = span_color_ff;
      last_in       = last_ff;
      if (do_store_lo) begin
         addr_lower_in = mul_addr;
      end
      if (do_store_hi) begin
         addr_upper_in = mul_addr;
         row_lower_in  = row_lower;
         row_upper_in  = row_upper;
         x_left_in     = x_left;
         x_right_in    = x_right;
         span_color_in = color_ff;
         last_in       = final_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         d_ff     <= '0;
         w_ff     <= '0;
         r_ff     <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         d_ff     <= d_in;
         w_ff     <= w_in;
         r_ff     <= r_in;
         last_ff  <= last_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      sq_ff         <= sq_in;
      v_ff          <= v_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      color_ff      <= color_in;
      row_lower_ff  <= row_lower_in;
      row_upper_ff  <= row_upper_in;
      x_left_ff     <= x_left_in;
      x_right_ff    <= x_right_in;
      addr_lower_ff <= addr_lower_in;
      addr_upper_ff <= addr_upper_in;
      span_color_ff <= span_color_in;
   end

   assign rsp_tdata = {2'b00, span_color_ff, addr_upper_ff, addr_lower_ff,
                       x_right_ff, x_left_ff, row_upper_ff, row_lower_ff};
   assign rsp_tlast = last_ff;

   // one side at a time: no request taken while a span pair is offered
   `CFS_ASSERT_SAME(a_one_side, clock, reset, rsp_tvalid, !req_tready, "req ready during rsp")

   // an offered half width is the floor root: (w+1)^2 is above the radicand
   `CFS_ASSERT_SAME(a_root_done, clock, reset, rsp_tvalid, sq_ff > v_ff, "half width not settled")

   // the final pair is marked exactly when the row offset reaches the radius
   `CFS_ASSERT_SAME(a_last_row, clock, reset, rsp_tvalid, rsp_tlast == final_row, "tlast mismatch")

   // a zero radius request yields nothing and frees the input again
   `CFS_ASSERT_NEXT(a_zero_radius, clock, reset, req_xfer && (req_radius == '0),
      req_tready && !rsp_tvalid, "zero radius not absorbed")

endmodule

// ----- tb/cfs_span_checker.sv -----
`timescale 1ns / 100ps

module cfs_span_checker
   import cfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,

   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tlast,

   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,

   output int                     fail_count,
   output int                     pending_spans
);

   typedef struct packed {
      logic [COLOR_W-1:0] span_color;
      logic [ADDR_W-1:0]  addr_upper;
      logic [ADDR_W-1:0]  addr_lower;
      logic [X_W-1:0]     x_right;
      logic [X_W-1:0]     x_left;
      logic [ROW_W-1:0]   row_upper;
      logic [ROW_W-1:0]   row_lower;
      logic               last;
   } span_pair_type;

   span_pair_type      expected_spans[$];
   span_pair_type      seen_pair;
   logic [ADDR_W-1:0]  frame_base;
   logic [PITCH_W-1:0] line_pitch;

   function automatic int unsigned floor_sqrt(input int unsigned v);
      int unsigned w;
      w = 0;
      while ((w + 1) * (w + 1) <= v)
         w++;
      return w;
   endfunction

   // byte address of a pixel, wraps at 32 bits like the hardware
   function automatic logic [ADDR_W-1:0] pixel_addr(input int row, input int col);
      logic [ADDR_W-1:0] a;
      a = frame_base + ADDR_W'(row) * ADDR_W'(line_pitch)
          + ADDR_W'(col) * ADDR_W'(BYTES_PER_PIXEL_DEF);
      return a;
   endfunction

   // queue one span pair per row offset of the circle
   task automatic predict_circle(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                                 input logic [RADIUS_W-1:0] rad, input logic [COLOR_W-1:0] color);
      int            r;
      int            w;
      int            rl;
      int            ru;
      int            xl;
      int            xr;
      span_pair_type sp;
      r = rad;
      if (r > MAX_RADIUS_DEF)
         r = MAX_RADIUS_DEF;
      for (int d = 1; d <= r; d++) begin
         w  = floor_sqrt(2 * r * d - d * d);
         rl = int'(cy) + r - d;
         ru = int'(cy) - r + d;
         xl = int'(cx) - w;
         xr = int'(cx) + w;
         sp.row_lower  = ROW_W'(rl);
         sp.row_upper  = ROW_W'(ru);
         sp.x_left     = X_W'(xl);
         sp.x_right    = X_W'(xr);
         sp.addr_lower = pixel_addr(rl, xl);
         sp.addr_upper = pixel_addr(ru, xl);
         sp.span_color = color;
         sp.last       = (d == r);
         expected_spans.push_back(sp);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      $display("%0t span check: %s got %h want %h", $realtime, what, got, want);
   endtask

   task automatic compare_pair(input span_pair_type got, input span_pair_type want);
      if (got.row_lower !== want.row_lower)
         report_mismatch("row_lower", 32'(got.row_lower), 32'(want.row_lower));
      if (got.row_upper !== want.row_upper)
         report_mismatch("row_upper", 32'(got.row_upper), 32'(want.row_upper));
      if (got.x_left !== want.x_left)
         report_mismatch("x_left", 32'(got.x_left), 32'(want.x_left));
      if (got.x_right !== want.x_right)
         report_mismatch("x_right", 32'(got.x_right), 32'(want.x_right));
      if (got.addr_lower !== want.addr_lower)
         report_mismatch("addr_lower", got.addr_lower, want.addr_lower);
      if (got.addr_upper !== want.addr_upper)
         report_mismatch("addr_upper", got.addr_upper, want.addr_upper);
      if (got.span_color !== want.span_color)
         report_mismatch("span_color", got.span_color, want.span_color);
      if (got.last !== want.last)
         report_mismatch("tlast", 32'(got.last), 32'(want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_base = FRAME_BASE_RST;
         line_pitch = LINE_PITCH_RST;
         expected_spans.delete();
         fail_count    = 0;
         pending_spans = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            {seen_pair.span_color, seen_pair.addr_upper, seen_pair.addr_lower,
             seen_pair.x_right, seen_pair.x_left, seen_pair.row_upper,
             seen_pair.row_lower} = rsp_tdata[149:0];
            seen_pair.last = rsp_tlast;
            if (expected_spans.size() == 0)
               report_mismatch("unexpected span pair, row_lower", 32'(seen_pair.row_lower), '0);
            else
               compare_pair(seen_pair, expected_spans.pop_front());
         end
         if (req_tvalid && req_tready)
            predict_circle(req_tdata[11:0], req_tdata[23:12], req_tdata[30:24],
                           req_tdata[62:31]);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FRAME_BASE: frame_base = csr_wdata;
               CSR_LINE_PITCH: line_pitch = csr_wdata[PITCH_W-1:0];
               default: ;
            endcase
         end
         pending_spans = expected_spans.size();
      end
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import cfs_pkg::*;

   // cycles with no transfer on either channel before the run is called hung
   localparam int IDLE_LIMIT   = 4000;
   // quiet cycles after the last span pair, covers a full radius-64 circle
   localparam int DRAIN_CYCLES = 400;
   // long receiver hold-off that backs the block up into its input
   localparam int HOLD_CYCLES  = 300;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int                     fail_count;
   int                     pending_spans;
   int                     idle_cycles;

   // shared with the receiver process
   bit                     stalls_on;
   bit                     hold_off_req;

   circle_fill_span_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predicts span pairs from observed transfers and compares
   cfs_span_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_spans (pending_spans)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: a run with no transfer for too long is hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int burst;
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_done) begin
            // hold-off counted here while the sender keeps offering circles
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one register write, entered and left on a falling edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // offer one circle and hold it until the transfer; entered on a falling edge
   task automatic send_circle(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                              input logic [RADIUS_W-1:0] rad, input logic [COLOR_W-1:0] color);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      // center_x, center_y, radius, color from bit 0 up, one pad bit on top
      req_tdata  <= {1'b0, color, rad, cy, cx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [CENTER_W-1:0] pick_center();
      int sel;
      sel = $urandom_range(0, 9);
      // edges now and then, so spans run off the top and left and past the far edges
      if (sel == 0)
         return CENTER_W'($urandom_range(0, 63));
      else if (sel == 1)
         return CENTER_W'($urandom_range(4032, 4095));
      return CENTER_W'($urandom);
   endfunction

   task automatic random_circle();
      int                  sel;
      logic [RADIUS_W-1:0] rad;
      sel = $urandom_range(0, 99);
      // mostly small circles, a few at and past the saturation point
      if (sel < 8)
         rad = '0;
      else if (sel < 80)
         rad = RADIUS_W'($urandom_range(1, 12));
      else if (sel < 90)
         rad = RADIUS_W'($urandom_range(13, 63));
      else if (sel < 95)
         rad = RADIUS_W'(MAX_RADIUS_DEF);
      else
         rad = RADIUS_W'($urandom_range(65, 127));
      send_circle(pick_center(), pick_center(), rad, $urandom);
   endtask

   // drop valid, wait for every span pair, then let the sequencer settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_spans != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] base_val,
                            input logic [CSR_DATA_W-1:0] pitch_val, input int n_items,
                            input bit with_hold);
      write_reg(CSR_FRAME_BASE, base_val);
      write_reg(CSR_LINE_PITCH, pitch_val);
      hold_off_req = with_hold;
      repeat (n_items) random_circle();
      drain();
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      stalls_on    = 1'b1;
      hold_off_req = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed circles under the reset register values
      send_circle(12'd0, 12'd0, 7'd0, 32'h0000_0000);         // zero radius
      send_circle(12'd100, 12'd200, 7'd1, 32'hFFFF_FFFF);      // single pair, center row
      send_circle(12'd100, 12'd200, 7'd2, 32'hA5A5_A5A5);
      send_circle(12'd2048, 12'd2048, 7'd64, 32'h1234_5678);   // largest radius
      send_circle(12'd0, 12'd0, 7'd64, 32'h8000_0001);         // negative rows and columns
      send_circle(12'd4095, 12'd4095, 7'd64, 32'h7FFF_FFFE);   // past the far edges
      send_circle(12'd4095, 12'd0, 7'd127, 32'hDEAD_BEEF);     // radius saturates
      send_circle(12'd0, 12'd4095, 7'd65, 32'h0F0F_0F0F);
      send_circle(12'd10, 12'd10, 7'd0, 32'hFFFF_FFFF);        // back-to-back zero radius
      send_circle(12'd11, 12'd11, 7'd0, 32'h5555_5555);
      send_circle(12'd300, 12'd300, 7'd3, 32'h0000_0000);
      send_circle(12'd2730, 12'd1365, 7'd42, 32'hC3C3_3C3C);
      send_circle(12'd1365, 12'd2730, 7'd21, 32'h3C3C_C3C3);
      drain();

      // extremes first, then mixed values; upper pitch bits must be dropped
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 62, 1'b1);
      run_phase(32'h0000_0000, 32'h0000_0000, 62, 1'b0);
      run_phase($urandom, $urandom, 62, 1'b0);
      // closing phase at full rate on both sides
      stalls_on = 1'b0;
      run_phase(32'h8000_0000, 32'hABCD_0001, 62, 1'b0);

      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cfs_pkg.sv
rtl/cfs_csr.sv
rtl/cfs_sqrt_step.sv
rtl/cfs_addr_unit.sv
rtl/circle_fill_span_generator.sv
tb/cfs_span_checker.sv
tb/tb_top.sv
